### hw/rtl/timing_wheel_event_scheduler_unit_defines.svh
// Assertion macros for the timing wheel scheduler RTL.
`ifndef TIMING_WHEEL_EVENT_SCHEDULER_UNIT_DEFINES_SVH
`define TIMING_WHEEL_EVENT_SCHEDULER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timing wheel assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timing wheel assertion failed");

`endif

### hw/rtl/tws_pkg.sv
// Types, constants and helper functions of the timing wheel scheduler.
`default_nettype none

package tws_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int SLOT_DIV = 256 / SLOTS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] KIND_INS_OK    = 2'd0;
    localparam logic [1:0] KIND_INS_FULL  = 2'd1;
    localparam logic [1:0] KIND_FIRED     = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] event_tag;
        logic [7:0] delay_ticks;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fired_tag;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] due;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SLOT_W-1:0] rd_addr;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
    } ram_req_t;

    typedef logic [SLOT_W-1:0] home_tab_t [256];

    function automatic home_tab_t build_home_tab();
        home_tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = SLOT_W'((i / SLOT_DIV) % SLOTS);
        end
        return tab;
    endfunction

    localparam home_tab_t HOME_TAB = build_home_tab();

    function automatic logic [SLOT_W-1:0] home_of(logic [7:0] t);
        return HOME_TAB[t];
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tws_slot_ram.sv
// Slot memory holding the tag and due time of every wheel slot.
`default_nettype none

module tws_slot_ram (
    input  logic              aclk,
    input  tws_pkg::ram_req_t req,
    output tws_pkg::entry_t   rd_data
);
    import tws_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/tws_out_reg.sv
// Output register that holds one result word until the consumer takes it.
`default_nettype none

module tws_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tws_pkg::out_word_t word,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output tws_pkg::out_word_t m_data
);
    import tws_pkg::*;

    logic      valid_reg;
    out_word_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= word;
        end
    end

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

### hw/rtl/tws_ctrl.sv
// Sequencer for insert probing and the tick walk over the slot memory.
`default_nettype none
`include "timing_wheel_event_scheduler_unit_defines.svh"

module tws_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tws_pkg::in_word_t  in_word,
    output logic               out_push,
    output tws_pkg::out_word_t out_word,
    input  logic               out_free,
    output tws_pkg::ram_req_t  ram_req,
    input  tws_pkg::entry_t    ram_rd_data
);
    import tws_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PROBE = 6'b000010,
        ST_CHK   = 6'b000100,
        ST_DATA  = 6'b001000,
        ST_SRCH  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        tick_reg, tick_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] want_reg, want_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        tag_reg, tag_next;
    logic [7:0]        due_reg, due_next;
    logic [1:0]        kind_reg, kind_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;

    logic [7:0]        tick_inc;
    logic [7:0]        ins_due;
    logic [SLOT_W-1:0] rd_home;
    logic              tick_take;

    assign tick_inc  = tick_reg + 8'd1;
    assign ins_due   = tick_reg + in_word.delay_ticks;
    assign rd_home   = home_of(ram_rd_data.due);
    assign in_ready  = (state_reg == ST_IDLE);
    assign tick_take = in_valid && in_ready && (in_word.opcode == OP_TICK);

    always_comb begin
        state_next = state_reg;
        tick_next  = tick_reg;
        pos_next   = pos_reg;
        want_next  = want_reg;
        cnt_next   = cnt_reg;
        tag_next   = tag_reg;
        due_next   = due_reg;
        kind_next  = kind_reg;
        occ_next   = occ_reg;
        ram_req    = '0;
        out_push   = 1'b0;
        out_word   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cnt_next = '0;
                    if (in_word.opcode == OP_TICK) begin
                        tick_next  = tick_inc;
                        pos_next   = home_of(tick_inc);
                        state_next = ST_CHK;
                    end else begin
                        due_next = ins_due;
                        tag_next = in_word.event_tag;
                        pos_next = home_of(ins_due);
                        if (in_word.event_tag == 8'd0) begin
                            kind_next  = KIND_INS_FULL;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE: begin
                if (cnt_reg == CNT_W'(SLOTS - 1)) begin
                    kind_next  = KIND_INS_FULL;
                    state_next = ST_DONE;
                end else if (!occ_reg[pos_reg]) begin
                    ram_req.wr_en       = 1'b1;
                    ram_req.wr_addr     = pos_reg;
                    ram_req.wr_data.tag = tag_reg;
                    ram_req.wr_data.due = due_reg;
                    occ_next[pos_reg]   = 1'b1;
                    kind_next           = KIND_INS_OK;
                    state_next          = ST_DONE;
                end else begin
                    pos_next = next_slot(pos_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CHK: begin
                if (cnt_reg == CNT_W'(SLOTS) || !occ_reg[pos_reg]) begin
                    kind_next  = KIND_TICK_DONE;
                    state_next = ST_DONE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = pos_reg;
                    state_next      = ST_DATA;
                end
            end
            ST_DATA: begin
                if (ram_rd_data.due == tick_reg) begin
                    if (out_free) begin
                        out_push           = 1'b1;
                        out_word.kind      = KIND_FIRED;
                        out_word.fired_tag = ram_rd_data.tag;
                        out_word.last      = 1'b0;
                        occ_next[pos_reg]  = 1'b0;
                        pos_next           = next_slot(pos_reg);
                        cnt_next           = cnt_reg + 1'b1;
                        state_next         = ST_CHK;
                    end
                end else if (rd_home == pos_reg) begin
                    pos_next   = next_slot(pos_reg);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_CHK;
                end else begin
                    want_next  = rd_home;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (want_reg == pos_reg) begin
                    kind_next  = KIND_TICK_DONE;
                    state_next = ST_DONE;
                end else if (!occ_reg[want_reg]) begin
                    ram_req.wr_en      = 1'b1;
                    ram_req.wr_addr    = want_reg;
                    ram_req.wr_data    = ram_rd_data;
                    occ_next[want_reg] = 1'b1;
                    occ_next[pos_reg]  = 1'b0;
                    pos_next           = next_slot(pos_reg);
                    cnt_next           = cnt_reg + 1'b1;
                    state_next         = ST_CHK;
                end else begin
                    want_next = next_slot(want_reg);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_push      = 1'b1;
                    out_word.kind = kind_reg;
                    out_word.last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tick_reg  <= 8'd0;
            occ_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        want_reg <= want_next;
        tag_reg  <= tag_next;
        due_reg  <= due_next;
        kind_reg <= kind_next;
    end

    `TWS_ASSERT_IMPL(a_push_when_free, aclk, aresetn, out_push, out_free)
    `TWS_ASSERT_IMPL(a_no_rw_overlap, aclk, aresetn, ram_req.wr_en, !ram_req.rd_en)
    `TWS_ASSERT_IMPL(a_write_free_slot, aclk, aresetn, ram_req.wr_en, !occ_reg[ram_req.wr_addr])
    `TWS_ASSERT_IMPL(a_data_occupied, aclk, aresetn, state_reg == ST_DATA, occ_reg[pos_reg])
    `TWS_ASSERT_NEXT(a_tick_advance, aclk, aresetn, tick_take, tick_reg == $past(tick_reg) + 8'd1)

endmodule

`default_nettype wire

### hw/rtl/timing_wheel_event_scheduler_unit.sv
// An insert probes one slot per cycle from the home slot of its due time until it finds a free slot.
// A tick reads each occupied slot from its home slot on, fires the entries that are due and moves
// a displaced entry to the first free slot from its home slot, stalling while the output is full.
// Throughput: one word at a time; the next word is taken once the last result is queued.
// Reset clears the occupancy flags, tick counter and control with no clearing pass;
// the slot memory contents are not reset.
`default_nettype none

module timing_wheel_event_scheduler_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tws_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tws_pkg::out_word_t m_data
);
    import tws_pkg::*;

    ram_req_t  ram_req;
    entry_t    ram_rd_data;
    logic      out_push;
    logic      out_free;
    out_word_t out_word;

    tws_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_word     (s_data),
        .out_push    (out_push),
        .out_word    (out_word),
        .out_free    (out_free),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    tws_slot_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    tws_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (out_push),
        .word    (out_word),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
